// File: design/bmh_pkg.sv
// Shared types, field widths and codes for the binary min-heap priority queue.
// No dependencies; imported by bmh_store, binary_min_heap_priority_queue and the testbench.
`default_nettype none

package bmh_pkg;

  localparam int KEY_W            = 32;
  localparam int OP_W             = 2;
  localparam int POS_W            = 8;
  localparam int STAT_W           = 2;
  localparam int CNT_OUT_W        = 8;
  localparam int CAPACITY_DEFAULT = 255;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [OP_W-1:0]         opcode_t;
  typedef logic [POS_W-1:0]        position_t;
  typedef logic [STAT_W-1:0]       status_t;
  typedef logic [CNT_OUT_W-1:0]    count_out_t;

  // Request opcodes
  localparam opcode_t OP_INSERT   = 2'd0;
  localparam opcode_t OP_EXTRACT  = 2'd1;
  localparam opcode_t OP_DECREASE = 2'd2;

  // Result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_BAD   = 2'd3;

endpackage

`default_nettype wire

// File: design/binary_min_heap_priority_queue.sv
// Binary min-heap priority queue: request sequencer with one shared key comparator.
// Depends on bmh_pkg and bmh_store.
// Throughput: one request at a time; busy stays high from accept to result.
// Reset: synchronous, active low; empties the heap and drops any request in flight.
// The result strobe out_valid lasts one cycle; the receiver cannot stall it.
`default_nettype none

module binary_min_heap_priority_queue #(
  parameter int CAPACITY = bmh_pkg::CAPACITY_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire bmh_pkg::opcode_t   in_opcode,
  input  wire bmh_pkg::key_t      in_key,
  input  wire bmh_pkg::position_t in_position,
  output logic                    out_valid,
  output bmh_pkg::status_t        out_status,
  output bmh_pkg::key_t           out_extracted_key,
  output bmh_pkg::key_t           out_minimum_key,
  output bmh_pkg::count_out_t     out_entry_count
);
  import bmh_pkg::*;

  // Slot index / count width; XW is wide enough to compare a position against count.
  localparam int AW = $clog2(CAPACITY + 1);
  localparam int XW = (AW > POS_W) ? AW + 1 : POS_W + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EX_ROOT,
    S_EX_LAST,
    S_DK_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_FIN_RD,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    hole_r, hole_nxt;      // slot the moving key currently owns
  logic [AW-1:0]    child_r, child_nxt;    // left child under test in sift-down
  key_t             key_r, key_nxt;        // key being sifted
  key_t             cand_r, cand_nxt;      // best of left child and sifted key
  logic             cand_left_r, cand_left_nxt;
  status_t          status_r, status_nxt;
  key_t             extr_r, extr_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  key_t             out_extr_r, out_extr_nxt;
  key_t             out_min_r, out_min_nxt;
  count_out_t       out_cnt_r, out_cnt_nxt;

  // Memory port
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  key_t             mem_wdata;
  logic [AW-1:0]    mem_raddr;
  key_t             mem_rdata;

  // Shared comparator
  key_t             cmp_a, cmp_b;
  logic             cmp_lt;

  logic [AW:0]      left_w, right_w;
  logic             right_ok;
  logic             accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign left_w   = {hole_r, 1'b0};
  assign right_w  = {1'b0, child_r} + (AW+1)'(1);
  assign right_ok = (right_w <= {1'b0, count_r});

  // Route operands to the single signed comparator by step
  always_comb begin
    unique case (state_r)
      S_DN_RDR: begin
        cmp_a = mem_rdata;
        cmp_b = key_r;
      end
      S_DN_CMP: begin
        cmp_a = mem_rdata;
        cmp_b = cand_r;
      end
      default: begin
        cmp_a = key_r;
        cmp_b = mem_rdata;
      end
    endcase
  end

  assign cmp_lt = (cmp_a < cmp_b);

  bmh_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    hole_nxt      = hole_r;
    child_nxt     = child_r;
    key_nxt       = key_r;
    cand_nxt      = cand_r;
    cand_left_nxt = cand_left_r;
    status_nxt    = status_r;
    extr_nxt      = extr_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_extr_nxt  = out_extr_r;
    out_min_nxt   = out_min_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = hole_r;
    mem_wdata     = key_r;
    mem_raddr     = AW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = ST_OK;
          extr_nxt   = '0;
          key_nxt    = in_key;
          priority case (in_opcode)
            OP_INSERT: begin
              if (count_r >= AW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_FIN_RD;
              end else begin
                // Open a hole at the new last slot and climb from there
                count_nxt = count_r + AW'(1);
                hole_nxt  = count_r + AW'(1);
                state_nxt = S_UP_RD;
              end
            end
            OP_EXTRACT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_FIN_RD;
              end else begin
                mem_raddr = AW'(1);
                state_nxt = S_EX_ROOT;
              end
            end
            OP_DECREASE: begin
              if (XW'(in_position) >= XW'(count_r)) begin
                status_nxt = ST_BAD;
                state_nxt  = S_FIN_RD;
              end else begin
                hole_nxt  = AW'(XW'(in_position) + XW'(1));
                mem_raddr = AW'(XW'(in_position) + XW'(1));
                state_nxt = S_DK_CMP;
              end
            end
            default: begin
              state_nxt = S_FIN_RD;
            end
          endcase
        end
      end

      S_EX_ROOT: begin
        // Capture the root, fetch the last key
        extr_nxt  = mem_rdata;
        mem_raddr = count_r;
        state_nxt = S_EX_LAST;
      end

      S_EX_LAST: begin
        key_nxt   = mem_rdata;
        count_nxt = count_r - AW'(1);
        hole_nxt  = AW'(1);
        state_nxt = S_DN_RDL;
      end

      S_DK_CMP: begin
        if (cmp_lt) begin
          state_nxt = S_UP_RD;
        end else begin
          status_nxt = ST_BAD;
          state_nxt  = S_FIN_RD;
        end
      end

      S_UP_RD: begin
        if (hole_r == AW'(1)) begin
          mem_we    = 1'b1;
          state_nxt = S_FIN_RD;
        end else begin
          mem_raddr = hole_r >> 1;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          // Parent moves down into the hole; hole climbs
          mem_wdata = mem_rdata;
          hole_nxt  = hole_r >> 1;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN_RD;
        end
      end

      S_DN_RDL: begin
        if (left_w > {1'b0, count_r}) begin
          mem_we    = 1'b1;
          state_nxt = S_FIN_RD;
        end else begin
          child_nxt = AW'(left_w);
          mem_raddr = AW'(left_w);
          state_nxt = S_DN_RDR;
        end
      end

      S_DN_RDR: begin
        // Left child against the sifted key; the right child is read meanwhile
        cand_left_nxt = cmp_lt;
        cand_nxt      = cmp_lt ? mem_rdata : key_r;
        mem_raddr     = right_ok ? AW'(right_w) : child_r;
        state_nxt     = S_DN_CMP;
      end

      S_DN_CMP: begin
        mem_we = 1'b1;
        if (right_ok && cmp_lt) begin
          mem_wdata = mem_rdata;
          hole_nxt  = AW'(right_w);
          state_nxt = S_DN_RDL;
        end else if (cand_left_r) begin
          mem_wdata = cand_r;
          hole_nxt  = child_r;
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = S_FIN_RD;
        end
      end

      S_FIN_RD: begin
        mem_raddr = AW'(1);
        state_nxt = S_FIN;
      end

      S_FIN: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        out_extr_nxt   = extr_r;
        out_min_nxt    = (count_r != '0) ? mem_rdata : '0;
        out_cnt_nxt    = CNT_OUT_W'(count_r);
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hole_r       <= hole_nxt;
    child_r      <= child_nxt;
    key_r        <= key_nxt;
    cand_r       <= cand_nxt;
    cand_left_r  <= cand_left_nxt;
    status_r     <= status_nxt;
    extr_r       <= extr_nxt;
    out_status_r <= out_status_nxt;
    out_extr_r   <= out_extr_nxt;
    out_min_r    <= out_min_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_extracted_key = out_extr_r;
  assign out_minimum_key   = out_min_r;
  assign out_entry_count   = out_cnt_r;

  // A result always lands with the sequencer back at rest
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  // Count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= AW'(CAPACITY)) else $error("entry count beyond capacity");

  // Storage is written only while a request is in flight
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> busy) else $error("store write while idle");

  // An accepted request raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request accepted but not busy");

  // A refused request reports no removed key
  a_extr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_extracted_key == '0))
    else $error("extracted key on a refused request");

endmodule

`default_nettype wire

// File: design/bmh_store.sv
// Key storage for the heap: one write port, one read port with registered data.
// Depends on bmh_pkg for the key type.
`default_nettype none

module bmh_store #(
  parameter int CAPACITY = bmh_pkg::CAPACITY_DEFAULT,
  parameter int AW       = $clog2(CAPACITY + 1)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire bmh_pkg::key_t wdata,
  input  wire logic [AW-1:0] raddr,
  output bmh_pkg::key_t      rdata
);
  import bmh_pkg::*;

  // Slot 0 is never used: slots are 1-based.
  key_t mem [0:CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking bench for binary_min_heap_priority_queue: drives insert, extract and
// decrease-key requests and checks every result against an internal heap model.
// Depends on bmh_pkg and the design sources only.
`timescale 1ns / 100ps

module testbench;
  import bmh_pkg::*;

  localparam int      HEAP_CAP     = CAPACITY_DEFAULT;
  localparam int      TOTAL_ITEMS  = 1950;
  localparam int      CYCLE_LIMIT  = 600000;
  localparam int      DRAIN_CYCLES = 40;
  localparam int      PRINT_CAP    = 40;
  // Opcode 3 has no name in the package; the block treats it as a no-op.
  localparam opcode_t OP_NOP       = 2'd3;
  localparam key_t    KEY_MAX      = 32'sh7FFF_FFFF;
  localparam key_t    KEY_MIN      = 32'sh8000_0000;

  typedef struct {
    opcode_t   opcode;
    key_t      key;
    position_t slot;
  } heap_request_t;

  typedef struct {
    status_t    status;
    key_t       extracted;
    key_t       minimum;
    count_out_t entries;
  } heap_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  opcode_t    in_opcode = OP_INSERT;
  key_t       in_key = '0;
  position_t  in_position = '0;
  logic       busy;
  logic       out_valid;
  status_t    out_status;
  key_t       out_extracted_key;
  key_t       out_minimum_key;
  count_out_t out_entry_count;

  binary_min_heap_priority_queue u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_key            (in_key),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_extracted_key (out_extracted_key),
    .out_minimum_key   (out_minimum_key),
    .out_entry_count   (out_entry_count)
  );

  // Model of the heap: 1-based slots, children of slot p at 2p and 2p+1.
  key_t heap_keys [1:HEAP_CAP];
  int   heap_count = 0;

  heap_request_t pending_requests[$];
  heap_result_t  awaited_results[$];
  heap_request_t live_request;
  logic          sender_idles = 1'b1;
  int            issued = 0;
  int            mismatches = 0;
  int            cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one accepted request to the model heap and return the result it must produce.
  function automatic heap_result_t heap_apply_request(heap_request_t req);
    heap_result_t res;
    int           p;
    int           child;
    int           pick;
    key_t         tmp;
    logic         settled;
    res = '{ST_OK, '0, '0, '0};
    p = 0;
    case (req.opcode)
      OP_INSERT: begin
        if (heap_count >= HEAP_CAP) begin
          res.status = ST_FULL;
        end else begin
          heap_count++;
          heap_keys[heap_count] = req.key;
          p = heap_count;
        end
      end
      OP_EXTRACT: begin
        if (heap_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.extracted = heap_keys[1];
          heap_keys[1] = heap_keys[heap_count];
          heap_count--;
          // Sift down: smaller child, left on a tie, swap only when strictly smaller.
          child = 1;
          settled = 1'b0;
          while (!settled) begin
            pick = 2 * child;
            if (pick > heap_count) begin
              settled = 1'b1;
            end else begin
              if (pick + 1 <= heap_count && heap_keys[pick + 1] < heap_keys[pick])
                pick = pick + 1;
              if (heap_keys[pick] < heap_keys[child]) begin
                tmp = heap_keys[pick];
                heap_keys[pick] = heap_keys[child];
                heap_keys[child] = tmp;
                child = pick;
              end else begin
                settled = 1'b1;
              end
            end
          end
        end
      end
      OP_DECREASE: begin
        if (int'(req.slot) >= heap_count) begin
          res.status = ST_BAD;
        end else if (!(req.key < heap_keys[int'(req.slot) + 1])) begin
          res.status = ST_BAD;
        end else begin
          p = int'(req.slot) + 1;
          heap_keys[p] = req.key;
        end
      end
      default: ;
    endcase
    // Sift up from the written slot, if any.
    while (p > 1 && heap_keys[p] < heap_keys[p / 2]) begin
      tmp = heap_keys[p];
      heap_keys[p] = heap_keys[p / 2];
      heap_keys[p / 2] = tmp;
      p = p / 2;
    end
    res.minimum = (heap_count > 0) ? heap_keys[1] : key_t'(0);
    res.entries = heap_count[CNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Driver: accept on start && !busy, then either hold the next request or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        awaited_results.push_back(heap_apply_request(live_request));
      // Hold a request that has not been taken yet; otherwise advance or idle.
      if (!(start && busy)) begin
        if (pending_requests.size() != 0 && !(sender_idles && $urandom_range(99) < 13)) begin
          live_request = pending_requests.pop_front();
          start       <= 1'b1;
          in_opcode   <= live_request.opcode;
          in_key      <= live_request.key;
          in_position <= live_request.slot;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe retires the oldest awaited result.
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result", {30'd0, out_status}, '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", {30'd0, out_status}, {30'd0, want.status});
        if (out_extracted_key !== want.extracted)
          report_mismatch("extracted_key", out_extracted_key, want.extracted);
        if (out_minimum_key !== want.minimum)
          report_mismatch("minimum_key", out_minimum_key, want.minimum);
        if (out_entry_count !== want.entries)
          report_mismatch("entry_count", {24'd0, out_entry_count}, {24'd0, want.entries});
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic queue_request(input opcode_t op, input key_t k, input int slot);
    pending_requests.push_back('{op, k, position_t'(slot)});
    issued++;
  endtask

  // Half small keys so ties and equal compares are common; the rest full-range and extremes.
  function automatic key_t random_key();
    int r;
    r = $urandom_range(99);
    if (r < 50) return key_t'($urandom_range(40)) - 20;
    if (r < 75) return key_t'($urandom);
    case ($urandom_range(3))
      0: return KEY_MAX - key_t'($urandom_range(3));
      1: return KEY_MIN + key_t'($urandom_range(3));
      2: return key_t'(0);
      default: return key_t'(-1);
    endcase
  endfunction

  // Build a decrease request against the model as it stands now.
  task automatic queue_decrease();
    int     r;
    int     slot;
    key_t   held;
    longint lowered;
    r = $urandom_range(99);
    if (heap_count == 0) begin
      queue_request(OP_DECREASE, random_key(), $urandom_range(254));
    end else if (heap_count < HEAP_CAP && r < 12) begin
      // Drop a request at a slot past the end of the heap.
      queue_request(OP_DECREASE, random_key(), $urandom_range(254, heap_count));
    end else begin
      slot = $urandom_range(heap_count - 1);
      held = heap_keys[slot + 1];
      r = $urandom_range(99);
      if (r < 15) begin
        queue_request(OP_DECREASE, held, slot);
      end else if (r < 25) begin
        queue_request(OP_DECREASE, held + key_t'($urandom_range(1000)), slot);
      end else if (r < 32) begin
        queue_request(OP_DECREASE, KEY_MIN, slot);
      end else begin
        lowered = longint'(held) - ((r < 70) ? longint'($urandom_range(1, 30))
                                              : longint'($urandom_range(1, 32'h4000_0000)));
        if (lowered < -64'sd2147483648) lowered = -64'sd2147483648;
        queue_request(OP_DECREASE, key_t'(lowered), slot);
      end
    end
  endtask

  // Wait until every request is taken and every result has arrived.
  task automatic settle();
    @(negedge clk);
    while (pending_requests.size() != 0 || start || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  // Fill past capacity, issue decreases on the full heap, then drain past empty.
  task automatic full_cycle();
    int extra;
    settle();
    extra = HEAP_CAP - heap_count + 3;
    for (int i = 0; i < extra; i++)
      queue_request(OP_INSERT, random_key(), $urandom_range(255));
    for (int i = 0; i < 20; i++) begin
      settle();
      queue_decrease();
    end
    settle();
    extra = heap_count + 2;
    for (int i = 0; i < extra; i++)
      queue_request(OP_EXTRACT, random_key(), $urandom_range(255));
  endtask

  // Short burst with a random insert bias, so the count wanders up and down.
  task automatic mixed_burst();
    int len;
    int bias;
    int r;
    settle();
    len = $urandom_range(4, 16);
    bias = $urandom_range(25, 60);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < bias)
        queue_request(OP_INSERT, random_key(), $urandom_range(255));
      else if (r < bias + 22)
        queue_request(OP_EXTRACT, random_key(), $urandom_range(255));
      else if (r < 97)
        queue_decrease();
      else
        queue_request(OP_NOP, random_key(), $urandom_range(255));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-heap corner cases, key extremes, refused decreases, ties.
    @(negedge clk);
    queue_request(OP_EXTRACT, KEY_MAX, 8'hFF);
    queue_request(OP_DECREASE, KEY_MIN, 0);
    queue_request(OP_NOP, '1, 8'hAA);
    queue_request(OP_INSERT, 0, 8'h55);
    queue_request(OP_INSERT, KEY_MAX, 0);
    queue_request(OP_INSERT, KEY_MIN, 0);
    queue_request(OP_INSERT, -1, 0);
    queue_request(OP_INSERT, 5, 0);
    queue_request(OP_INSERT, 5, 0);
    queue_request(OP_DECREASE, KEY_MIN, 0);   // equal to the root: refused
    queue_request(OP_DECREASE, 0, 254);       // past the end: refused
    queue_request(OP_DECREASE, -5, 3);        // valid, climbs one level
    queue_request(OP_DECREASE, 5, 5);         // equal key: refused
    queue_request(OP_DECREASE, 7, 4);         // larger key: refused
    queue_request(OP_NOP, KEY_MAX, 8'hFF);
    for (int i = 0; i < 7; i++)
      queue_request(OP_EXTRACT, 0, 0);        // equal keys on the way down

    // Random: one full cycle with no idling, mixed bursts, another full cycle, more bursts.
    settle();
    sender_idles = 1'b0;
    full_cycle();
    settle();
    sender_idles = 1'b1;
    while (issued < TOTAL_ITEMS / 2)
      mixed_burst();
    full_cycle();
    while (issued < TOTAL_ITEMS)
      mixed_burst();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/bmh_pkg.sv
design/bmh_store.sv
design/binary_min_heap_priority_queue.sv
tb/sv/testbench.sv
